@@ sv/fpa_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed-point alu package
// shared types, operation codes and constants for the q24.8 alu
// ----------------------------------------------------------------------------
package fpa_pkg;

	localparam int FRAC_BITS_DEF = 8;
	// divisor register holds twice the operand magnitude
	localparam int DIV_DW        = 33;

	typedef enum logic [3:0] {
		MODE_ADD  = 4'd0,
		MODE_SUB  = 4'd1,
		MODE_MUL  = 4'd2,
		MODE_DIV  = 4'd3,
		MODE_MIN  = 4'd4,
		MODE_MAX  = 4'd5,
		MODE_INC  = 4'd6,
		MODE_DEC  = 4'd7,
		MODE_I2F  = 4'd8,
		MODE_F2I  = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		KIND_PASS = 2'd0,
		KIND_MUL  = 2'd1,
		KIND_DIV  = 2'd2
	} kind_t;

	typedef struct packed {
		logic [3:0]         mode;
		logic signed [31:0] operand_a;
		logic signed [31:0] operand_b;
	} cmd_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic               a_less;
		logic               a_greater;
		logic               a_equal;
		logic               overflow;
		logic               divide_by_zero;
	} rsp_t;

	// word side information carried along the cell chain
	typedef struct packed {
		kind_t              kind;
		logic signed [63:0] r;
		logic               neg;
		logic               chk;
		logic               lt;
		logic               gt;
		logic               eq;
		logic               dz;
	} ctl_t;

endpackage
`default_nettype wire

@@ sv/fixed_point_alu_q24_8.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fixed-point alu q24.8
// signed 32-bit fixed-point alu, exact multiply and divide with rounding
// ----------------------------------------------------------------------------
// every word passes the input register, the chain of divider cells (one quotient
// bit per cell) and the output register on its way from start to done.
// throughput: one word per cycle, busy stays low; every word takes the chain.
// reset clears the valid bits of all stages; no word is in flight after it.
module fixed_point_alu_q24_8
	import fpa_pkg::*;
#(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  cmd_t      cmd,
	output logic      busy,
	output logic      done,
	output rsp_t      rsp
);

	localparam int NW = 33 + FRACTION_BITS;
	localparam int AW = 32 + FRACTION_BITS;

	logic signed [63:0] a64, b64, prod;
	logic [31:0]        am, dm;
	logic [NW-1:0]      num;
	ctl_t               ctl_d;

	always_comb begin
		a64  = {{32{cmd.operand_a[31]}}, cmd.operand_a};
		b64  = {{32{cmd.operand_b[31]}}, cmd.operand_b};
		prod = a64 * b64;
		am   = cmd.operand_a[31] ? 32'(-cmd.operand_a) : 32'(cmd.operand_a);
		dm   = cmd.operand_b[31] ? 32'(-cmd.operand_b) : 32'(cmd.operand_b);
		num  = {am, {FRACTION_BITS{1'b0}}, 1'b0} + NW'(dm);
		ctl_d.kind = KIND_PASS;
		ctl_d.r    = '0;
		ctl_d.neg  = cmd.operand_a[31] ^ cmd.operand_b[31];
		ctl_d.chk  = 1'b1;
		ctl_d.lt   = cmd.operand_a < cmd.operand_b;
		ctl_d.gt   = cmd.operand_a > cmd.operand_b;
		ctl_d.eq   = cmd.operand_a == cmd.operand_b;
		ctl_d.dz   = 1'b0;
		unique case (mode_t'(cmd.mode))
			MODE_ADD: ctl_d.r = a64 + b64;
			MODE_SUB: ctl_d.r = a64 - b64;
			MODE_MUL: begin
				ctl_d.kind = KIND_MUL;
				ctl_d.r    = prod;
			end
			MODE_DIV: begin
				if (cmd.operand_b == '0) begin
					ctl_d.dz  = 1'b1;
					ctl_d.chk = 1'b0;
				end else begin
					ctl_d.kind = KIND_DIV;
				end
			end
			MODE_MIN: ctl_d.r = ctl_d.lt ? a64 : b64;
			MODE_MAX: ctl_d.r = ctl_d.gt ? a64 : b64;
			MODE_INC: ctl_d.r = a64 + 64'sd1;
			MODE_DEC: ctl_d.r = a64 - 64'sd1;
			MODE_I2F: ctl_d.r = a64 <<< FRACTION_BITS;
			MODE_F2I: ctl_d.r = a64 >>> FRACTION_BITS;
			default:  ctl_d.chk = 1'b0;
		endcase
	end

	logic              vld_c [0:NW];
	ctl_t              ctl_c [0:NW];
	logic [DIV_DW-1:0] rem_c [0:NW];
	logic [DIV_DW-1:0] den_c [0:NW];
	logic [NW-1:0]     sh_c  [0:NW];

	logic              vld_s1;
	ctl_t              ctl_s1;
	logic [DIV_DW-1:0] den_s1;
	logic [NW-1:0]     num_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		ctl_s1 <= ctl_d;
		den_s1 <= {dm, 1'b0};
		num_s1 <= num;
	end

	assign vld_c[0] = vld_s1;
	assign ctl_c[0] = ctl_s1;
	assign rem_c[0] = '0;
	assign den_c[0] = den_s1;
	assign sh_c[0]  = num_s1;

	for (genvar i = 0; i < NW; i++) begin : g_cell
		fpa_div_cell #(.NW(NW)) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_c[i]),
			.ctl_in  (ctl_c[i]),
			.rem_in  (rem_c[i]),
			.den_in  (den_c[i]),
			.sh_in   (sh_c[i]),
			.vld_out (vld_c[i+1]),
			.ctl_out (ctl_c[i+1]),
			.rem_out (rem_c[i+1]),
			.den_out (den_c[i+1]),
			.sh_out  (sh_c[i+1])
		);
	end

	ctl_t               ctl_l;
	logic signed [63:0] q64, fin;
	logic               ovf;

	always_comb begin
		ctl_l = ctl_c[NW];
		q64   = {{(64-NW){1'b0}}, sh_c[NW]};
		case (ctl_l.kind)
			// round half away from zero: add half, less one when negative
			KIND_MUL: fin = $signed(ctl_l.r + (64'sd1 <<< (FRACTION_BITS - 1))
				- {63'd0, ctl_l.r[63]}) >>> FRACTION_BITS;
			KIND_DIV: fin = ctl_l.neg ? -q64 : q64;
			default:  fin = ctl_l.r;
		endcase
		ovf = ctl_l.chk && !((&fin[63:31]) || !(|fin[63:31]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= vld_c[NW];
		end
	end

	always_ff @(posedge clk) begin
		rsp.result         <= fin[31:0];
		rsp.a_less         <= ctl_l.lt;
		rsp.a_greater      <= ctl_l.gt;
		rsp.a_equal        <= ctl_l.eq;
		rsp.overflow       <= ovf;
		rsp.divide_by_zero <= ctl_l.dz;
	end

	assign busy = 1'b0;

	logic unused_ok;
	assign unused_ok = ^{AW, rem_c[NW], den_c[NW]};

endmodule
`default_nettype wire

@@ sv/fpa_div_cell.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa divider cell
// one restoring division step per cell, passes the word on each cycle
// ----------------------------------------------------------------------------
module fpa_div_cell
	import fpa_pkg::*;
#(
	parameter int NW = 41
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              vld_in,
	input  ctl_t                   ctl_in,
	input  wire logic [DIV_DW-1:0] rem_in,
	input  wire logic [DIV_DW-1:0] den_in,
	input  wire logic [NW-1:0]     sh_in,
	output logic                   vld_out,
	output ctl_t                   ctl_out,
	output logic [DIV_DW-1:0]      rem_out,
	output logic [DIV_DW-1:0]      den_out,
	output logic [NW-1:0]          sh_out
);

	logic [DIV_DW:0]   trial;
	logic              qbit;
	logic [DIV_DW:0]   diff;

	always_comb begin
		trial = {rem_in, sh_in[NW-1]};
		diff  = trial - {1'b0, den_in};
		qbit  = (trial >= {1'b0, den_in});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_out <= 1'b0;
		end else begin
			vld_out <= vld_in;
		end
	end

	always_ff @(posedge clk) begin
		ctl_out <= ctl_in;
		den_out <= den_in;
		// numerator bits leave at the top, quotient bits enter at the bottom
		sh_out  <= {sh_in[NW-2:0], qbit};
		rem_out <= qbit ? diff[DIV_DW-1:0] : trial[DIV_DW-1:0];
	end

endmodule
`default_nettype wire

@@ sv/fpa_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fpa port checker
// watches the top level ports for flag and timing consistency
// ----------------------------------------------------------------------------
module fpa_checker
	import fpa_pkg::*;
#(
	parameter int FRACTION_BITS = FRAC_BITS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input cmd_t      cmd,
	input wire logic busy,
	input wire logic done,
	input rsp_t      rsp
);

	localparam int LAT = 35 + FRACTION_BITS;

	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("busy raised");

	a_done_lat: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start, LAT))
		else $error("word delivered without matching start");

	a_cmp_one: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $onehot({rsp.a_less, rsp.a_greater, rsp.a_equal}))
		else $error("compare flags not exclusive");

	a_dz: assert property (@(posedge clk) disable iff (!arst_n)
		done && rsp.divide_by_zero |-> rsp.result == '0 && !rsp.overflow)
		else $error("divide by zero word malformed");

	logic unused_ok;
	assign unused_ok = ^cmd;

endmodule

bind fixed_point_alu_q24_8 fpa_checker #(.FRACTION_BITS(FRACTION_BITS)) u_fpa_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.cmd    (cmd),
	.busy   (busy),
	.done   (done),
	.rsp    (rsp)
);
`default_nettype wire
